// File: rtl/core/assert_macros.svh
// Assertion macros shared by the bloom filter set RTL.
// Each macro expands to one labeled concurrent assertion clocked by clk and
// disabled while rst_n is low; the using module must provide both signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/bfs_pkg.sv
// Package for the bloom filter set unit: opcodes, hash constants, FSM and
// sequencer types, and the control/status structs of the probe engine.
// No dependencies.
`default_nettype none

package bfs_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } bfs_state_t;

  // Steps of the shared-multiplier hash sequencer.
  typedef enum logic [3:0] {
    HS_M1_LL,
    HS_M1_LH,
    HS_M1_HL,
    HS_M2_LL,
    HS_M2_LH,
    HS_M2_HL,
    HS_Q1,
    HS_R1,
    HS_Q2,
    HS_R2
  } hash_step_t;

  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FMIX_SHIFT = 33;

  localparam int unsigned ROW_W = 64;
  localparam int unsigned BIT_W = 6;

  localparam int unsigned NH_W    = 5;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_NUM_HASHES = '0;
  localparam logic [NH_W-1:0]    NUM_HASHES_RST = 5'd2;

  typedef struct packed {
    logic            go_probe;
    logic            go_clear;
    logic            is_add;
    logic [NH_W-1:0] count;
  } prb_ctrl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } prb_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bfs_hash.sv
// Key scrambler and modulo reduction for the bloom filter set unit.
// Runs the 64-bit finalizer and both residues on one shared 32x32 multiplier.
// Depends on bfs_pkg.
`default_nettype none

module bfs_hash #(
  parameter int unsigned STORE_BYTES = 16384,
  localparam int unsigned STORE_BITS = STORE_BYTES * 8,
  localparam int unsigned IDX_W = $clog2(STORE_BITS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [63:0]      key_hash,
  output logic                  done,
  output logic [IDX_W-1:0]      base,
  output logic [IDX_W-1:0]      step
);

  localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / 64'(STORE_BITS);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [31:0] M32     = 32'(STORE_BITS);

  bfs_pkg::hash_step_t step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [63:0]        x_r, x_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [IDX_W-1:0]   base_r, base_nxt;
  logic [IDX_W-1:0]   step_mod_r, step_mod_nxt;

  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] mix;
  logic [31:0] raw, red;

  assign prod = op_a * op_b;
  assign mix  = acc_r + {prod[31:0], 32'd0};
  // The quotient estimate is low by at most one, so one correction suffices.
  assign raw  = ((step_r == bfs_pkg::HS_R1) ? x_r[31:0] : x_r[63:32]) - prod[31:0];
  assign red  = (raw >= M32) ? (raw - M32) : raw;

  always_comb begin
    op_a         = x_r[31:0];
    op_b         = bfs_pkg::FMIX_C1[31:0];
    step_nxt     = step_r;
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    x_nxt        = x_r;
    acc_nxt      = acc_r;
    q_nxt        = q_r;
    base_nxt     = base_r;
    step_mod_nxt = step_mod_r;
    if (go) begin
      x_nxt    = key_hash ^ (key_hash >> bfs_pkg::FMIX_SHIFT);
      busy_nxt = 1'b1;
      step_nxt = bfs_pkg::HS_M1_LL;
    end else if (busy_r) begin
      case (step_r)
        bfs_pkg::HS_M1_LL: begin
          op_b     = bfs_pkg::FMIX_C1[31:0];
          acc_nxt  = prod;
          step_nxt = bfs_pkg::HS_M1_LH;
        end
        bfs_pkg::HS_M1_LH: begin
          op_b     = bfs_pkg::FMIX_C1[63:32];
          acc_nxt  = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
          step_nxt = bfs_pkg::HS_M1_HL;
        end
        bfs_pkg::HS_M1_HL: begin
          op_a     = x_r[63:32];
          op_b     = bfs_pkg::FMIX_C1[31:0];
          x_nxt    = mix ^ (mix >> bfs_pkg::FMIX_SHIFT);
          step_nxt = bfs_pkg::HS_M2_LL;
        end
        bfs_pkg::HS_M2_LL: begin
          op_b     = bfs_pkg::FMIX_C2[31:0];
          acc_nxt  = prod;
          step_nxt = bfs_pkg::HS_M2_LH;
        end
        bfs_pkg::HS_M2_LH: begin
          op_b     = bfs_pkg::FMIX_C2[63:32];
          acc_nxt  = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
          step_nxt = bfs_pkg::HS_M2_HL;
        end
        bfs_pkg::HS_M2_HL: begin
          op_a     = x_r[63:32];
          op_b     = bfs_pkg::FMIX_C2[31:0];
          x_nxt    = mix ^ (mix >> bfs_pkg::FMIX_SHIFT);
          step_nxt = bfs_pkg::HS_Q1;
        end
        bfs_pkg::HS_Q1: begin
          op_b     = RECIP;
          q_nxt    = prod[63:32];
          step_nxt = bfs_pkg::HS_R1;
        end
        bfs_pkg::HS_R1: begin
          op_a     = q_r;
          op_b     = M32;
          base_nxt = red[IDX_W-1:0];
          step_nxt = bfs_pkg::HS_Q2;
        end
        bfs_pkg::HS_Q2: begin
          op_a     = x_r[63:32];
          op_b     = RECIP;
          q_nxt    = prod[63:32];
          step_nxt = bfs_pkg::HS_R2;
        end
        bfs_pkg::HS_R2: begin
          op_a         = q_r;
          op_b         = M32;
          step_mod_nxt = red[IDX_W-1:0];
          busy_nxt     = 1'b0;
          done_nxt     = 1'b1;
          step_nxt     = bfs_pkg::HS_M1_LL;
        end
        default: begin
          busy_nxt = 1'b0;
          step_nxt = bfs_pkg::HS_M1_LL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= bfs_pkg::HS_M1_LL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    base_r     <= base_nxt;
    step_mod_r <= step_mod_nxt;
  end

  assign done = done_r;
  assign base = base_r;
  assign step = step_mod_r;

endmodule

`default_nettype wire

// File: rtl/core/bfs_probe.sv
// Probe engine of the bloom filter set unit: the bit store in 64-bit rows,
// read-modify-write with one-deep forwarding, and the row-by-row clear sweep.
// Depends on bfs_pkg.
`default_nettype none

module bfs_probe #(
  parameter int unsigned STORE_BYTES = 16384,
  localparam int unsigned STORE_BITS = STORE_BYTES * 8,
  localparam int unsigned IDX_W = $clog2(STORE_BITS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bfs_pkg::prb_ctrl_t ctrl,
  input  wire logic [IDX_W-1:0]   base,
  input  wire logic [IDX_W-1:0]   step,
  output bfs_pkg::prb_stat_t      stat
);

  localparam int unsigned ROWS   = (STORE_BYTES + 7) / 8;
  localparam int unsigned ROW_AW = (IDX_W > bfs_pkg::BIT_W) ? (IDX_W - bfs_pkg::BIT_W) : 1;
  localparam int unsigned NW     = ROW_AW + bfs_pkg::BIT_W;
  localparam logic [IDX_W:0]    M_EXT    = (IDX_W + 1)'(STORE_BITS);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  logic [bfs_pkg::ROW_W-1:0] mem [ROWS];
  logic [bfs_pkg::ROW_W-1:0] rd_q_r;

  logic                       prb_active_r;
  logic                       clr_active_r;
  logic [ROW_AW-1:0]          clr_cnt_r;
  logic [bfs_pkg::NH_W-1:0]   rem_r;
  logic                       s2_vld_r;
  logic                       wr_vld_r;
  logic [IDX_W-1:0]           n_r;
  logic [IDX_W-1:0]           d_r;
  logic                       is_add_r;
  logic                       hit_r;
  logic [ROW_AW-1:0]          s2_row_r;
  logic [bfs_pkg::BIT_W-1:0]  s2_bit_r;
  logic [ROW_AW-1:0]          wr_row_r;
  logic [bfs_pkg::ROW_W-1:0]  wr_data_r;

  logic [NW-1:0]              n_pad;
  logic [ROW_AW-1:0]          rd_row;
  logic [bfs_pkg::BIT_W-1:0]  rd_bit;
  logic [IDX_W:0]             n_sum;
  logic [IDX_W-1:0]           n_adv;
  logic [bfs_pkg::ROW_W-1:0]  eff_row;
  logic                       probe_bit;
  logic                       issue;
  logic                       prb_done;
  logic                       clr_done;
  logic                       we;
  logic [ROW_AW-1:0]          wa;
  logic [bfs_pkg::ROW_W-1:0]  wd;

  assign n_pad  = NW'(n_r);
  assign rd_row = n_pad[NW-1:bfs_pkg::BIT_W];
  assign rd_bit = n_pad[bfs_pkg::BIT_W-1:0];

  // Both terms are already reduced, so the next probe needs one compare-subtract.
  assign n_sum = {1'b0, n_r} + {1'b0, d_r};
  always_comb begin
    if (n_sum >= M_EXT) begin
      n_adv = IDX_W'(n_sum - M_EXT);
    end else begin
      n_adv = n_sum[IDX_W-1:0];
    end
  end

  // A row written at the edge that captured this read is taken from the write path.
  assign eff_row   = (wr_vld_r && (wr_row_r == s2_row_r)) ? wr_data_r : rd_q_r;
  assign probe_bit = eff_row[s2_bit_r];

  assign issue    = prb_active_r && (rem_r != '0);
  assign prb_done = prb_active_r && (rem_r == '0) && !s2_vld_r;
  assign clr_done = clr_active_r && (clr_cnt_r == LAST_ROW);

  assign we = clr_active_r || (s2_vld_r && is_add_r);
  assign wa = clr_active_r ? clr_cnt_r : s2_row_r;
  assign wd = clr_active_r ? '0 : (eff_row | (bfs_pkg::ROW_W'(1) << s2_bit_r));

  assign stat = '{done: (clr_done || prb_done), hit: hit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prb_active_r <= 1'b0;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      rem_r        <= '0;
      s2_vld_r     <= 1'b0;
      wr_vld_r     <= 1'b0;
    end else begin
      if (ctrl.go_clear) begin
        clr_active_r <= 1'b1;
        clr_cnt_r    <= '0;
      end else if (clr_done) begin
        clr_active_r <= 1'b0;
      end else if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (ctrl.go_probe) begin
        prb_active_r <= 1'b1;
        rem_r        <= ctrl.count;
      end else if (prb_done) begin
        prb_active_r <= 1'b0;
      end else if (issue) begin
        rem_r <= rem_r - 1'b1;
      end
      s2_vld_r <= issue;
      wr_vld_r <= s2_vld_r && is_add_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go_probe) begin
      n_r      <= base;
      d_r      <= step;
      is_add_r <= ctrl.is_add;
      hit_r    <= 1'b1;
    end else begin
      if (issue) begin
        n_r <= n_adv;
      end
      if (s2_vld_r && !is_add_r) begin
        hit_r <= hit_r & probe_bit;
      end
    end
    s2_row_r  <= rd_row;
    s2_bit_r  <= rd_bit;
    wr_row_r  <= wa;
    wr_data_r <= wd;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q_r <= mem[rd_row];
  end

endmodule

`default_nettype wire

// File: rtl/core/bloom_filter_set_unit.sv
// Add or query: busy after start while the key is hashed and the probes run; a query result follows.
// One probe per cycle on the bit store's single read and write port, once hashing is done.
// Clear: busy while all STORE_BYTES/8 rows, rounded up (2048 by default), are zeroed, one row per cycle.
// Reset (synchronous, rst_n low) runs the same clearing pass before start is taken.
// The result strobe cannot be stalled; each result is shown for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"

// Top level of the bloom filter set unit. Instantiates the hash sequencer and
// the probe engine; depends on bfs_pkg, bfs_hash, bfs_probe and the macros.
module bloom_filter_set_unit #(
  parameter int unsigned STORE_BYTES = 16384
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [63:0]                   in_key_hash,
  output logic                               out_valid,
  output logic                               out_maybe_present,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfs_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int unsigned STORE_BITS = STORE_BYTES * 8;
  localparam int unsigned IDX_W      = $clog2(STORE_BITS);

  bfs_pkg::bfs_state_t       state_r, state_nxt;
  logic [bfs_pkg::NH_W-1:0]  num_hashes_r;
  logic [1:0]                op_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_mp_r;

  logic                      accept;
  logic                      cfg_write;
  logic                      go_hash;
  logic                      hash_done;
  logic [IDX_W-1:0]          hash_base;
  logic [IDX_W-1:0]          hash_step;
  bfs_pkg::prb_ctrl_t        prb_ctrl;
  bfs_pkg::prb_stat_t        prb_stat;

  // A transaction on the command side is taken whenever the unit is idle.
  assign busy   = (state_r != bfs_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Configuration: a single register, num_hashes; paddr is two bits wide, so every address selects it.
  // pready is tied high, so every access completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = bfs_pkg::PDATA_W'(num_hashes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_hashes_r <= bfs_pkg::NUM_HASHES_RST;
    end else if (cfg_write && ((paddr >> 2) == bfs_pkg::REG_NUM_HASHES)) begin
      num_hashes_r <= pwdata[bfs_pkg::NH_W-1:0];
    end
  end

  // Next-state logic. An unused opcode is accepted and dropped in the idle state.
  // The probe engine's done flag means the sweep in the clear state and the end
  // of the last probe in the probe state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            bfs_pkg::OP_ADD:   state_nxt = bfs_pkg::ST_HASH;
            bfs_pkg::OP_QUERY: state_nxt = bfs_pkg::ST_HASH;
            bfs_pkg::OP_CLEAR: state_nxt = bfs_pkg::ST_CLEAR;
            default:           state_nxt = bfs_pkg::ST_IDLE;
          endcase
        end
      end
      bfs_pkg::ST_HASH: begin
        if (hash_done) begin
          state_nxt = bfs_pkg::ST_PROBE;
        end
      end
      bfs_pkg::ST_PROBE: begin
        if (prb_stat.done) begin
          state_nxt = bfs_pkg::ST_IDLE;
        end
      end
      bfs_pkg::ST_CLEAR: begin
        if (prb_stat.done) begin
          state_nxt = bfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfs_pkg::ST_CLEAR;
    endcase
  end

  // Output decode of the state machine.
  always_comb begin
    go_hash           = 1'b0;
    prb_ctrl.go_probe = 1'b0;
    prb_ctrl.go_clear = 1'b0;
    prb_ctrl.is_add   = (op_r == bfs_pkg::OP_ADD);
    prb_ctrl.count    = num_hashes_r;
    out_valid_nxt     = 1'b0;
    case (state_r)
      bfs_pkg::ST_IDLE: begin
        go_hash           = accept && ((in_opcode == bfs_pkg::OP_ADD) ||
                                       (in_opcode == bfs_pkg::OP_QUERY));
        prb_ctrl.go_clear = accept && (in_opcode == bfs_pkg::OP_CLEAR);
      end
      bfs_pkg::ST_HASH: begin
        prb_ctrl.go_probe = hash_done;
      end
      bfs_pkg::ST_PROBE: begin
        out_valid_nxt = prb_stat.done && (op_r == bfs_pkg::OP_QUERY);
      end
      bfs_pkg::ST_CLEAR: begin
        go_hash = 1'b0;
      end
      default: begin
        go_hash = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfs_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Opcode of the transaction in flight, and the registered query answer.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
    end
    out_mp_r <= prb_stat.hit;
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

  // The hash sequencer scrambles the key and reduces both halves modulo the
  // store size; the probe engine then walks the probes one per cycle.
  bfs_hash #(
    .STORE_BYTES(STORE_BYTES)
  ) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go_hash),
    .key_hash (in_key_hash),
    .done     (hash_done),
    .base     (hash_base),
    .step     (hash_step)
  );

  bfs_probe #(
    .STORE_BYTES(STORE_BYTES)
  ) u_probe (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (prb_ctrl),
    .base  (hash_base),
    .step  (hash_step),
    .stat  (prb_stat)
  );

  // A result only ever appears once the unit has returned to idle.
  `ASSERT_IMPL(a_result_when_idle, out_valid, state_r == bfs_pkg::ST_IDLE)
  // The hash sequencer only finishes while the state machine is waiting for it.
  `ASSERT_IMPL(a_hash_done_in_hash, hash_done, state_r == bfs_pkg::ST_HASH)
  // An accepted clear transaction makes the unit busy on the next cycle.
  `ASSERT_NEXT(a_clear_goes_busy, accept && (in_opcode == bfs_pkg::OP_CLEAR), busy)

endmodule

`default_nettype wire

// File: verif/bloom_filter_set_unit_test.sv
// Self-checking testbench for the bloom filter set unit: directed and random add, query and
// clear traffic, with probe-count changes over the APB port. Depends on bfs_pkg and the
// bloom_filter_set_unit RTL only.

// Mirror of the bit store that predicts every query answer and checks it in order.
class presence_scoreboard #(int unsigned STORE_BYTES = 16384);
  localparam int unsigned STORE_BITS = STORE_BYTES * 8;
  localparam bit [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam bit [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam bit [4:0] PROBES_AFTER_RESET = 5'd2;

  bit          store_bits [STORE_BITS];
  bit [4:0]    probe_count;
  bit          presence_q [$];
  int unsigned mismatches;

  function new();
    probe_count = PROBES_AFTER_RESET;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return presence_q.size();
  endfunction

  // The fmix64 finalizer: xor-shift, multiply, xor-shift, multiply, xor-shift.
  function bit [63:0] scramble_key(bit [63:0] key);
    bit [63:0] h;
    h = key;
    h ^= h >> 33;
    h = h * MIX_MUL_A;
    h ^= h >> 33;
    h = h * MIX_MUL_B;
    h ^= h >> 33;
    return h;
  endfunction

  // Record one accepted transaction and, for a query, queue the expected answer.
  function void note_item(logic [1:0] op, bit [63:0] key);
    bit [63:0] mixed;
    bit [63:0] slot;
    bit        all_set;
    if (op == bfs_pkg::OP_CLEAR) begin
      foreach (store_bits[n]) store_bits[n] = 1'b0;
      return;
    end
    if (op != bfs_pkg::OP_ADD && op != bfs_pkg::OP_QUERY) return;
    mixed = scramble_key(key);
    all_set = 1'b1;
    for (int unsigned i = 0; i < probe_count; i++) begin
      // The sum fits in 64 bits, so only the final modulo folds it into the store.
      slot = ({32'd0, mixed[31:0]} + 64'(i) * {32'd0, mixed[63:32]}) % 64'(STORE_BITS);
      if (op == bfs_pkg::OP_ADD) store_bits[slot] = 1'b1;
      else if (!store_bits[slot]) all_set = 1'b0;
    end
    if (op == bfs_pkg::OP_QUERY) presence_q.push_back(all_set);
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  task check_result(logic got);
    bit want;
    if (presence_q.size() == 0) begin
      report_mismatch($sformatf("result maybe_present=%b with no query outstanding", got));
      return;
    end
    want = presence_q.pop_front();
    if (got !== want)
      report_mismatch($sformatf("maybe_present=%b, predicted %b", got, want));
  endtask
endclass

module bloom_filter_set_unit_test;

  localparam int unsigned STORE_BYTES = 16384;
  // The longest correct quiet stretch is a clearing pass plus a sender gap;
  // this limit leaves a wide margin over that.
  localparam int unsigned QUIET_LIMIT = 20000;
  // An add or query runs longer as num_hashes grows, and num_hashes can reach 31.
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int unsigned PHASES = 8;
  localparam int unsigned KEY_POOL_MAX = 64;
  // Opcode 3 has no meaning; the block must accept and ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [1:0]                   in_opcode;
  logic [63:0]                  in_key_hash;
  logic                         out_valid;
  logic                         out_maybe_present;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bfs_pkg::PADDR_W-1:0]  paddr;
  logic [bfs_pkg::PDATA_W-1:0]  pwdata;
  logic [bfs_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  presence_scoreboard #(STORE_BYTES) sb;

  // The latest keys added since the last clear, KEY_POOL_MAX at most; unflipped queries drawn from here should hit.
  bit [63:0]   added_keys [$];
  int unsigned quiet_cycles;

  bloom_filter_set_unit #(.STORE_BYTES(STORE_BYTES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_key_hash      (in_key_hash),
    .out_valid        (out_valid),
    .out_maybe_present(out_maybe_present),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be stalled, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_maybe_present);
  end

  // The watchdog restarts on any accepted transaction, result or register access.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. The start line is
  // left high so that a following transaction can be presented without a gap.
  task automatic issue(logic [1:0] op, bit [63:0] key);
    start <= 1'b1;
    in_opcode <= op;
    in_key_hash <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, key);
  endtask

  // Stop sending and wait until every answer has come back and the block has gone idle,
  // then give it the full latency once more in case a trailing add is still probing.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the probe count followed by a read back. The upper data bits carry
  // random junk, which the five-bit register must drop.
  task automatic write_probe_count(bit [4:0] value);
    bit [26:0] junk;
    junk = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bfs_pkg::REG_NUM_HASHES;
    pwdata <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.probe_count = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {27'd0, value})
      sb.report_mismatch($sformatf("num_hashes read back %0h, wrote %0h", prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Occasional sender gaps; their random length spreads them over all stages of a probe run.
  task automatic maybe_pause();
    if ($urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  // Random traffic. Most queries reuse keys added since the last clear, some with one bit
  // flipped, so hits and near misses are both common. Clears are rare because each one
  // walks the whole store. Ignored opcodes do not count toward the phase length.
  task automatic random_phase(int unsigned count, bit with_gaps);
    int unsigned sent;
    int unsigned pick;
    bit [63:0]   key;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(999);
      key = {$urandom(), $urandom()};
      if (pick < 8) begin
        issue(bfs_pkg::OP_CLEAR, key);
        added_keys.delete();
        sent++;
      end else if (pick < 30) begin
        issue(OP_UNUSED, key);
      end else if (pick < 480) begin
        issue(bfs_pkg::OP_ADD, key);
        added_keys.push_back(key);
        if (added_keys.size() > KEY_POOL_MAX) void'(added_keys.pop_front());
        sent++;
      end else begin
        if (added_keys.size() != 0 && $urandom_range(9) < 6) begin
          key = added_keys[$urandom_range(added_keys.size() - 1)];
          if ($urandom_range(3) == 0) key[$urandom_range(63)] ^= 1'b1;
        end
        issue(bfs_pkg::OP_QUERY, key);
        sent++;
      end
      if (with_gaps) maybe_pause();
    end
  endtask

  initial begin
    bit [4:0] phase_probes [PHASES];

    sb = new();
    quiet_cycles = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= bfs_pkg::OP_ADD;
    in_key_hash <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset setting of two probes. The block is still clearing after
    // reset, so the first transaction also checks that start waits on busy.
    issue(bfs_pkg::OP_QUERY, 64'h0);
    issue(bfs_pkg::OP_ADD, 64'h0);
    issue(bfs_pkg::OP_QUERY, 64'h0);
    issue(bfs_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(bfs_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(bfs_pkg::OP_QUERY, 64'h5555_5555_5555_5555);
    issue(bfs_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(bfs_pkg::OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    // After a clear, keys that were present must read as absent.
    issue(bfs_pkg::OP_CLEAR, 64'h0);
    issue(bfs_pkg::OP_QUERY, 64'h0);
    issue(bfs_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // Largest legal probe count.
    write_probe_count(5'd16);
    issue(bfs_pkg::OP_ADD, 64'h1);
    issue(bfs_pkg::OP_QUERY, 64'h1);
    issue(bfs_pkg::OP_QUERY, 64'h2);
    drain();

    // With zero probes an add touches nothing and every query answers present.
    write_probe_count(5'd0);
    issue(bfs_pkg::OP_ADD, 64'h0123_4567_89AB_CDEF);
    issue(bfs_pkg::OP_QUERY, 64'hFEDC_BA98_7654_3210);
    drain();

    // Probe counts above the legal range are used as written.
    write_probe_count(5'd31);
    issue(bfs_pkg::OP_ADD, 64'h8000_0000_0000_0000);
    issue(bfs_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
    issue(bfs_pkg::OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
    drain();

    // A single probe lands on the first bit the wide add above has already set.
    write_probe_count(5'd1);
    issue(bfs_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
    drain();

    // Random part: each phase runs at its own probe count and starts from an idle block.
    // Phase 2 sends without any gaps at all.
    phase_probes = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd0, 5'd0, 5'd0, 5'd16};
    phase_probes[5] = 5'($urandom_range(1, 16));
    phase_probes[6] = 5'($urandom_range(3, 12));
    for (int p = 0; p < PHASES; p++) begin
      write_probe_count(phase_probes[p]);
      random_phase(ITEMS_PER_PHASE, p != 2);
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
